// ----- design/hrf_pkg.sv -----
// ----------------------------------------------------------------------------
// hrf_pkg: shared types and constants of the HTTP request framer.
// Holds the byte token passed from the classifier to the parser and the
// output codes.
// ----------------------------------------------------------------------------
package hrf_pkg;

  localparam int unsigned NameLen = 14;

  typedef enum logic [2:0] {
    CLS_METHOD  = 3'd0,
    CLS_URI     = 3'd1,
    CLS_VERSION = 3'd2,
    CLS_NAME    = 3'd3,
    CLS_VALUE   = 3'd4,
    CLS_DELIM   = 3'd5,
    CLS_BODY    = 3'd6
  } hrf_class_t;

  typedef enum logic [1:0] {
    METH_OTHER = 2'd0,
    METH_GET   = 2'd1,
    METH_POST  = 2'd2
  } hrf_method_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_NO_DIGIT = 2'd2,
    ERR_OVERFLOW = 2'd3
  } hrf_error_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // One classified stream beat.
  typedef struct packed {
    logic [7:0]  data;
    logic        is_space;
    logic        is_cr;
    logic        is_lf;
    logic        is_colon;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] name_eq;
  } hrf_token_t;

  function automatic logic [7:0] length_name_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h4c; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/hrf_front.sv -----
// ----------------------------------------------------------------------------
// hrf_front: byte classifier.
// Flags delimiters and digits of each incoming beat and compares it against
// every character of the Content-Length header name.
// ----------------------------------------------------------------------------
module hrf_front
  import hrf_pkg::*;
(
  input  logic [7:0] data_byte,
  output hrf_token_t token
);

  logic [15:0] name_eq;

  always_comb begin
    name_eq = '0;
    for (int i = 0; i < NameLen; i++) begin
      name_eq[i] = (data_byte == length_name_char(4'(i)));
    end
  end

  always_comb begin
    token.data     = data_byte;
    token.is_space = (data_byte == ChSpace);
    token.is_cr    = (data_byte == ChCr);
    token.is_lf    = (data_byte == ChLf);
    token.is_colon = (data_byte == ChColon);
    token.is_digit = (data_byte >= ChZero) && (data_byte <= ChNine);
    token.digit    = 4'(data_byte - ChZero);
    token.name_eq  = name_eq;
  end

endmodule

// ----- design/hrf_queue.sv -----
// ----------------------------------------------------------------------------
// hrf_queue: short token queue between classifier and parser.
// A small register FIFO that lets each side stall independently.
// ----------------------------------------------------------------------------
module hrf_queue
  import hrf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hrf_token_t push_token,
  output logic       full,
  input  logic       pop,
  output hrf_token_t head_token,
  output logic       not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  hrf_token_t          mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full       = (count_r == CntW'(DEPTH));
  assign not_empty  = (count_r != '0);
  assign head_token = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// ----- design/hrf_back.sv -----
// ----------------------------------------------------------------------------
// hrf_back: request parser.
// Walks the request phases for each token, decodes the method, tracks the
// Content-Length header and counts out the body; results sit in an output
// register.
// ----------------------------------------------------------------------------
module hrf_back
  import hrf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  hrf_token_t  q_token,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_class,
  output logic [1:0]  out_method_code,
  output logic [31:0] out_body_length,
  output logic        out_message_done,
  output logic [1:0]  out_error_code
);

  localparam int unsigned PW = LENGTH_BITS + 4;
  localparam int unsigned OW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  typedef enum logic [10:0] {
    PH_METHOD     = 11'b000_0000_0001,
    PH_URI        = 11'b000_0000_0010,
    PH_VERSION    = 11'b000_0000_0100,
    PH_VERSION_CR = 11'b000_0000_1000,
    PH_NAME       = 11'b000_0001_0000,
    PH_SKIP       = 11'b000_0010_0000,
    PH_VALUE      = 11'b000_0100_0000,
    PH_VALUE_CR   = 11'b000_1000_0000,
    PH_BLANK_CR   = 11'b001_0000_0000,
    PH_BODY       = 11'b010_0000_0000,
    PH_VALUE_TAIL = 11'b100_0000_0000
  } hrf_phase_t;

  hrf_phase_t             phase_r, phase_nxt;
  logic [3:0]             mmatch_r, mmatch_nxt;
  logic [3:0]             npos_r, npos_nxt;
  logic                   is_len_r, is_len_nxt;
  logic                   len_seen_r, len_seen_nxt;
  logic                   dig_seen_r, dig_seen_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic                   empty_r, empty_nxt;

  logic                   out_valid_r, out_valid_nxt;
  hrf_class_t             out_cls_r, cls;
  hrf_method_t            out_meth_r, meth;
  logic [31:0]            out_len_r;
  logic                   out_done_r, done;
  hrf_error_t             out_err_r, err;

  logic [PW-1:0]          prod;
  logic                   ovf;
  logic [LENGTH_BITS-1:0] remain_dec;

  function automatic logic [3:0] method_next(input logic [3:0] m, input logic [7:0] c);
    logic [3:0] r;
    case (m)
      4'd0:    r = (c == 8'h47) ? 4'd1 : ((c == 8'h50) ? 4'd4 : 4'd8);
      4'd1:    r = (c == 8'h45) ? 4'd2 : 4'd8;
      4'd2:    r = (c == 8'h54) ? 4'd3 : 4'd8;
      4'd4:    r = (c == 8'h4f) ? 4'd5 : 4'd8;
      4'd5:    r = (c == 8'h53) ? 4'd6 : 4'd8;
      4'd6:    r = (c == 8'h54) ? 4'd7 : 4'd8;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  assign q_pop         = q_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop || (out_valid_r && out_stall);

  assign prod = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + PW'(q_token.digit);
  assign ovf  = |prod[PW-1:LENGTH_BITS];
  assign remain_dec = remain_r - 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    mmatch_nxt   = mmatch_r;
    npos_nxt     = npos_r;
    is_len_nxt   = is_len_r;
    len_seen_nxt = len_seen_r;
    dig_seen_nxt = dig_seen_r;
    accum_nxt    = accum_r;
    remain_nxt   = remain_r;
    empty_nxt    = empty_r;
    cls          = CLS_DELIM;
    err          = ERR_NONE;
    done         = 1'b0;

    case (phase_r)
      PH_URI: begin
        if (q_token.is_space) phase_nxt = PH_VERSION;
        else cls = CLS_URI;
      end
      PH_VERSION: begin
        if (q_token.is_cr) phase_nxt = PH_VERSION_CR;
        else cls = CLS_VERSION;
      end
      PH_VERSION_CR: begin
        if (q_token.is_lf) begin
          phase_nxt = PH_NAME;
          empty_nxt = 1'b1;
          npos_nxt  = '0;
        end else if (!q_token.is_cr) begin
          phase_nxt = PH_VERSION;
          cls       = CLS_VERSION;
        end
      end
      PH_NAME: begin
        if (empty_r && q_token.is_cr) begin
          phase_nxt = PH_BLANK_CR;
        end else if (q_token.is_colon) begin
          if ((npos_r == 4'(NameLen)) && !len_seen_r) begin
            is_len_nxt   = 1'b1;
            len_seen_nxt = 1'b1;
          end
          phase_nxt = PH_SKIP;
        end else begin
          cls       = CLS_NAME;
          empty_nxt = 1'b0;
          npos_nxt  = q_token.name_eq[npos_r] ? npos_r + 1'b1 : 4'hf;
        end
      end
      PH_SKIP: begin
        phase_nxt = is_len_r ? PH_VALUE : PH_VALUE_TAIL;
        empty_nxt = 1'b1;
      end
      PH_VALUE, PH_VALUE_TAIL: begin
        if (q_token.is_cr) begin
          phase_nxt = PH_VALUE_CR;
        end else begin
          cls       = CLS_VALUE;
          empty_nxt = 1'b0;
          if (phase_r == PH_VALUE) begin
            if (q_token.is_digit) begin
              if (ovf) begin
                err = ERR_OVERFLOW;
              end else begin
                accum_nxt    = prod[LENGTH_BITS-1:0];
                dig_seen_nxt = 1'b1;
              end
            end else if (!(q_token.is_space && !dig_seen_r)) begin
              phase_nxt = PH_VALUE_TAIL;
            end
          end
        end
      end
      PH_VALUE_CR: begin
        if (q_token.is_lf) begin
          if (is_len_r) begin
            if (empty_r) err = ERR_EMPTY;
            else if (!dig_seen_r) err = ERR_NO_DIGIT;
          end
          phase_nxt  = PH_NAME;
          empty_nxt  = 1'b1;
          npos_nxt   = '0;
          is_len_nxt = 1'b0;
        end else if (!q_token.is_cr) begin
          empty_nxt = 1'b0;
          phase_nxt = PH_VALUE_TAIL;
          cls       = CLS_VALUE;
        end else begin
          empty_nxt = 1'b0;
        end
      end
      PH_BLANK_CR: begin
        if (accum_r == '0) begin
          done = 1'b1;
        end else begin
          remain_nxt = accum_r;
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        cls        = CLS_BODY;
        remain_nxt = remain_dec;
        if (remain_dec == '0) done = 1'b1;
      end
      default: begin
        if (q_token.is_space) begin
          phase_nxt = PH_URI;
        end else begin
          cls        = CLS_METHOD;
          mmatch_nxt = method_next(mmatch_r, q_token.data);
        end
      end
    endcase

    case (mmatch_nxt)
      4'd3:    meth = METH_GET;
      4'd7:    meth = METH_POST;
      default: meth = METH_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      mmatch_r    <= '0;
      npos_r      <= '0;
      is_len_r    <= 1'b0;
      len_seen_r  <= 1'b0;
      dig_seen_r  <= 1'b0;
      accum_r     <= '0;
      remain_r    <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (done || (err != ERR_NONE)) begin
          phase_r    <= PH_METHOD;
          mmatch_r   <= '0;
          npos_r     <= '0;
          is_len_r   <= 1'b0;
          len_seen_r <= 1'b0;
          dig_seen_r <= 1'b0;
          accum_r    <= '0;
          remain_r   <= '0;
          empty_r    <= 1'b1;
        end else begin
          phase_r    <= phase_nxt;
          mmatch_r   <= mmatch_nxt;
          npos_r     <= npos_nxt;
          is_len_r   <= is_len_nxt;
          len_seen_r <= len_seen_nxt;
          dig_seen_r <= dig_seen_nxt;
          accum_r    <= accum_nxt;
          remain_r   <= remain_nxt;
          empty_r    <= empty_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_cls_r  <= cls;
      out_meth_r <= meth;
      out_len_r  <= 32'(accum_nxt[OW-1:0]);
      out_done_r <= done;
      out_err_r  <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_class   = out_cls_r;
  assign out_method_code  = out_meth_r;
  assign out_body_length  = out_len_r;
  assign out_message_done = out_done_r;
  assign out_error_code   = out_err_r;

`ifndef NO_ASSERTIONS
  a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && (out_err_r != ERR_NONE)))
    else $error("beat marked both done and in error");

  a_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (done || (err != ERR_NONE))) |=> (phase_r == PH_METHOD) && (accum_r == '0))
    else $error("parser did not return to a new request");

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (remain_r != '0))
    else $error("body phase with nothing left to count");

  a_body_class: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (phase_r == PH_BODY)) |=> (out_cls_r == CLS_BODY))
    else $error("body beat not labelled as body");
`endif

endmodule

// ----- design/http_request_framer.sv -----
// A byte accepted at the input is written into the queue, then into the hrf_back output register.
// Throughput: one byte per cycle while out_stall is low, set by the parser step in hrf_back.
// A queue of QUEUE_DEPTH beats between classifier and parser absorbs output stalls.
// Reset is synchronous and active low; it empties the queue and restores the parser
// to the start of a request.
// ----------------------------------------------------------------------------
// http_request_framer: HTTP/1.1 request framer with Content-Length bodies.
// Labels each request byte, decodes the method, tracks the first
// Content-Length header and flags the byte that completes each request.
// ----------------------------------------------------------------------------
module http_request_framer
  import hrf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_class,
  output logic [1:0]  out_method_code,
  output logic [31:0] out_body_length,
  output logic        out_message_done,
  output logic [1:0]  out_error_code
);

  hrf_token_t in_token;
  hrf_token_t head_token;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  hrf_front u_front (
    .data_byte (in_data_byte),
    .token     (in_token)
  );

  hrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (in_token),
    .full       (q_full),
    .pop        (q_pop),
    .head_token (head_token),
    .not_empty  (q_not_empty)
  );

  hrf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_token          (head_token),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_class   (out_byte_class),
    .out_method_code  (out_method_code),
    .out_body_length  (out_body_length),
    .out_message_done (out_message_done),
    .out_error_code   (out_error_code)
  );

endmodule
